/* src/ptb_pkg.sv */
package ptb_pkg;

    // bank geometry
    localparam int SLOTS       = 16;
    localparam int COUNT_WIDTH = 32;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // fixed word widths
    localparam int PERIOD_W = 32;
    localparam int CFG_W    = 16;
    localparam int OP_W     = 2;
    localparam int SLOTF_W  = 4;

    // command codes
    localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
    localparam logic [OP_W-1:0] OP_ARM    = 2'd1;
    localparam logic [OP_W-1:0] OP_DISARM = 2'd2;

    // fit a period word to the counter width (truncate or zero extend)
    function automatic logic [COUNT_WIDTH-1:0] fit_count(input logic [PERIOD_W-1:0] v);
        logic [63:0] ext;
        ext = 64'(v);
        return ext[COUNT_WIDTH-1:0];
    endfunction

endpackage

/* src/ptb_div.sv */
// Restoring divider, one quotient bit per cycle.
module ptb_div
    import ptb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [PERIOD_W-1:0] i_num,
    input  logic [CFG_W-1:0]    i_den,
    output logic                o_done,
    output logic [PERIOD_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(PERIOD_W);

    logic                r_busy;
    logic [CNT_W-1:0]    r_cnt;
    logic [PERIOD_W-1:0] r_num;
    logic [CFG_W-1:0]    r_den;
    logic [CFG_W-1:0]    r_rem;
    logic                r_done;

    logic [CFG_W:0]      n_shift;
    logic [CFG_W:0]      n_diff;
    logic                n_qbit;

    // trial subtract of the shifted partial remainder
    always_comb begin
        n_shift = {r_rem, r_num[PERIOD_W-1]};
        n_diff  = n_shift - {1'b0, r_den};
        n_qbit  = (n_shift >= {1'b0, r_den});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(PERIOD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend register shifts out, quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= n_qbit ? n_diff[CFG_W-1:0] : n_shift[CFG_W-1:0];
            r_num <= {r_num[PERIOD_W-2:0], n_qbit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

/* src/periodic_timer_bank.sv */
// Bank of SLOTS periodic countdown timers. A tick command walks every slot with one
// shared decrementer, one slot per cycle, keeping busy high through the walk and a
// flush state; its fire words come out in ascending slot order during and right
// after the walk; the final word of every command has o_last set. An arm in ticks
// or a disarm goes through the ack state. An arm in microseconds runs the period
// through a bit-serial divider (one quotient bit per cycle) and waits for its result.
// Result words are strobed by o_valid for exactly one cycle and cannot be
// held off. Write us_per_tick only while busy is low and no word is pending.
module periodic_timer_bank
    import ptb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OP_W-1:0]     i_op,
    input  logic [SLOTF_W-1:0]  i_slot,
    input  logic [PERIOD_W-1:0] i_period,
    input  logic                i_period_in_ticks,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_wdata,
    output logic                o_valid,
    output logic [SLOTF_W-1:0]  o_fired_slot,
    output logic                o_fired,
    output logic                o_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_FLUSH,
        S_DIV,
        S_ACK
    } t_state;

    t_state                 r_state;
    logic [CFG_W-1:0]       r_us_per_tick;
    logic [SLOT_W-1:0]      r_idx;
    logic [SLOT_W-1:0]      r_arm_slot;
    logic [SLOTS-1:0]       r_active;
    logic                   r_pend;
    logic [SLOT_W-1:0]      r_pend_slot;
    logic [COUNT_WIDTH-1:0] r_countdown [SLOTS];
    logic [COUNT_WIDTH-1:0] r_reload    [SLOTS];

    logic                   n_accept;
    logic                   n_slot_ok;
    logic [SLOT_W-1:0]      n_slot_idx;
    logic [COUNT_WIDTH-1:0] n_dec;
    logic                   n_fire;
    logic                   n_div_start;
    logic [CFG_W-1:0]       n_div_den;
    logic                   div_done;
    logic [PERIOD_W-1:0]    div_quot;
    logic                   n_load;
    logic [SLOT_W-1:0]      n_load_slot;
    logic [COUNT_WIDTH-1:0] n_load_val;
    logic [63:0]            n_slot_ext;

    // command decode
    always_comb begin
        n_accept    = start && (r_state == S_IDLE);
        n_slot_ext  = 64'(i_slot);
        n_slot_idx  = n_slot_ext[SLOT_W-1:0];
        n_slot_ok   = (32'(i_slot) < 32'(SLOTS));
        n_div_start = n_accept && (i_op == OP_ARM) && n_slot_ok && !i_period_in_ticks;
        n_div_den   = (r_us_per_tick == '0) ? CFG_W'(1) : r_us_per_tick;
    end

    // shared decrementer on the slot under the walk
    always_comb begin
        n_dec  = r_countdown[r_idx] - 1'b1;
        n_fire = (r_state == S_SWEEP) && r_active[r_idx] && (n_dec == '0);
    end

    // slot load from either a tick-unit arm or the divider
    always_comb begin
        n_load      = 1'b0;
        n_load_slot = n_slot_idx;
        n_load_val  = fit_count(i_period);
        if (n_accept && (i_op == OP_ARM) && n_slot_ok && i_period_in_ticks) begin
            n_load = 1'b1;
        end else if ((r_state == S_DIV) && div_done) begin
            n_load      = 1'b1;
            n_load_slot = r_arm_slot;
            n_load_val  = fit_count(div_quot);
        end
    end

    ptb_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (n_div_start),
        .i_num   (i_period),
        .i_den   (n_div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // sequencer, active marks and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_us_per_tick <= CFG_W'(1);
            r_active      <= '0;
            r_idx         <= '0;
            r_pend        <= 1'b0;
            o_valid       <= 1'b0;
            o_fired       <= 1'b0;
            o_last        <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            o_fired <= 1'b0;
            o_last  <= 1'b0;
            if (i_cfg_we) begin
                r_us_per_tick <= i_cfg_wdata;
            end
            if (n_load) begin
                r_active[n_load_slot] <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (n_accept) begin
                        r_idx  <= '0;
                        r_pend <= 1'b0;
                        if (i_op == OP_TICK) begin
                            r_state <= S_SWEEP;
                        end else if (n_div_start) begin
                            r_state <= S_DIV;
                        end else begin
                            if ((i_op == OP_DISARM) && n_slot_ok) begin
                                r_active[n_slot_idx] <= 1'b0;
                            end
                            r_state <= S_ACK;
                        end
                    end
                end
                S_SWEEP: begin
                    // a new expiry pushes out the previous one, not last
                    if (n_fire) begin
                        r_pend <= 1'b1;
                        if (r_pend) begin
                            o_valid <= 1'b1;
                            o_fired <= 1'b1;
                        end
                    end
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == SLOT_W'(SLOTS - 1)) begin
                        r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    o_valid <= 1'b1;
                    o_fired <= r_pend;
                    o_last  <= 1'b1;
                    r_state <= S_IDLE;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_ACK;
                    end
                end
                S_ACK: begin
                    o_valid <= 1'b1;
                    o_last  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // counters, reload values and result payload
    always_ff @(posedge i_clk) begin
        logic [63:0] slot_ext;
        slot_ext = 64'(r_pend_slot);
        if (n_accept) begin
            r_arm_slot <= n_slot_idx;
        end
        if (n_load) begin
            r_countdown[n_load_slot] <= n_load_val;
            r_reload[n_load_slot]    <= n_load_val;
        end else if ((r_state == S_SWEEP) && r_active[r_idx]) begin
            r_countdown[r_idx] <= n_fire ? r_reload[r_idx] : n_dec;
        end
        if (n_fire) begin
            r_pend_slot <= r_idx;
        end
        o_fired_slot <= '0;
        if ((r_state == S_SWEEP) && n_fire && r_pend) begin
            o_fired_slot <= slot_ext[SLOTF_W-1:0];
        end else if ((r_state == S_FLUSH) && r_pend) begin
            o_fired_slot <= slot_ext[SLOTF_W-1:0];
        end
    end

    assign busy = (r_state != S_IDLE);

    // an empty word always closes its command
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_fired) |-> (o_last && (o_fired_slot == '0)))
        else $error("empty word without last or with nonzero slot");

    // an accepted command makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command accepted but block not busy");

    // divider results only arrive while waiting for them
    a_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside its wait state");

    // no words while idle except the one closing the previous command
    a_word_timing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (r_state == S_SWEEP || r_state == S_FLUSH))
        else $error("fire word outside a tick walk");

endmodule
